>>> rtl/core/perq_pkg.sv
// Shared types and constants for the priority evicting request queue.
package perq_pkg;

  // Operation codes carried in the func field
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_DEQUEUED = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_FLUSHED  = 3'd5;

  // Width of the capacity register and its reset value
  localparam int unsigned CAP_W     = 7;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  // One stored queue entry
  typedef struct packed {
    logic [7:0]  priority_val;
    logic [31:0] request_id;
    logic [7:0]  source_id;
    logic [31:0] frame_number;
  } entry_t;

  // Input item
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] request_id;
    logic [7:0]  source_id;
    logic [31:0] frame_number;
    logic [7:0]  priority_req;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_request_id;
    logic [7:0]  out_source_id;
    logic [31:0] out_frame_number;
    logic [7:0]  out_priority;
    logic [6:0]  occupancy;
    logic        last;
  } rsp_t;

  // Build a result, with or without an entry attached
  function automatic rsp_t make_rsp(input logic [2:0] status, input logic has_entry,
                                    input entry_t ent, input logic [6:0] occ,
                                    input logic last);
    rsp_t r;
    r.status           = status;
    r.out_request_id   = has_entry ? ent.request_id   : 32'd0;
    r.out_source_id    = has_entry ? ent.source_id    : 8'd0;
    r.out_frame_number = has_entry ? ent.frame_number : 32'd0;
    r.out_priority     = has_entry ? ent.priority_val : 8'd0;
    r.occupancy        = occ;
    r.last             = last;
    return r;
  endfunction

endpackage

>>> rtl/core/priority_evicting_request_queue.sv
// Top level: bounded request queue with lowest-priority eviction.
//
//  channel   ports                          handshake
//  --------  -----------------------------  ----------------------------------
//  command   cmd (cmd_t)                    taken when start && !busy
//  result    result (rsp_t)                 result_valid strobe, one cycle
//  config    cfg_data                       written when cfg_we
//
// Push below the limit and flush finish in the accept cycle; a pop of a non-empty
// queue reads the head from memory first. A push at the limit scans all held entries
// through the single memory read port; if any has a lower priority than the pushed
// item, the lowest is evicted, the entries behind it move toward the head one per
// cycle and the push is appended, else the push is rejected. Busy until it is done.
// Synchronous reset empties the queue and sets the capacity to 64; no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module priority_evicting_request_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  perq_pkg::cmd_t                cmd,
  input  logic                          cfg_we,
  input  logic [perq_pkg::CAP_W-1:0]    cfg_data,
  output logic                          result_valid,
  output perq_pkg::rsp_t                result
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > perq_pkg::CAP_W) ? CW : perq_pkg::CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_X = (CW+1)'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t                       state;
  logic [CW-1:0]                fill;
  logic [AW-1:0]                head;
  logic [perq_pkg::CAP_W-1:0]   capacity;
  perq_pkg::entry_t             pend;
  perq_pkg::entry_t             best;
  logic [CW-1:0]                issue_cnt;
  logic                         rd_pending;
  logic [AW-1:0]                cmp_idx;
  logic [7:0]                   lowest;
  logic [AW-1:0]                best_idx;
  logic                         found;
  logic [CW-1:0]                sh_rd;
  logic                         sh_wr_valid;
  logic [AW-1:0]                sh_wr_idx;

  logic                         accept;
  logic                         full;
  logic [perq_pkg::CAP_W-1:0]   cap_nz;
  perq_pkg::entry_t             in_entry;
  logic                         scan_issue;
  logic                         shift_issue;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  perq_pkg::entry_t             wr_data;
  logic [AW-1:0]                rd_addr;
  perq_pkg::entry_t             rd_data;

  // Map a position in the queue to a memory address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(hd) + (CW+1)'(i);
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[AW-1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Effective limit check: capacity clamped to 1..depth
  assign cap_nz = (capacity == '0) ? perq_pkg::CAP_W'(1) : capacity;
  assign full   = (fill == DEPTH_C) || (LW'(fill) >= LW'(cap_nz));

  // Pack the pushed item as an entry
  always_comb begin
    in_entry.priority_val = cmd.priority_req;
    in_entry.request_id   = cmd.request_id;
    in_entry.source_id    = cmd.source_id;
    in_entry.frame_number = cmd.frame_number;
  end

  assign scan_issue  = (issue_cnt < fill);
  assign shift_issue = (sh_rd < fill);

  // Select the memory read address
  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = phys(head, issue_cnt);
      S_SHIFT: rd_addr = phys(head, sh_rd);
      default: rd_addr = head;
    endcase
  end

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head, fill);
    wr_data = in_entry;
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.func == perq_pkg::FUNC_PUSH && !full) begin
          wr_en = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sh_wr_valid) begin
          wr_en   = 1'b1;
          wr_addr = phys(head, CW'(sh_wr_idx));
          wr_data = rd_data;
        end else if (!shift_issue) begin
          wr_en   = 1'b1;
          wr_addr = phys(head, fill - CW'(1));
          wr_data = pend;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  perq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= perq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // Sequence each item: accept, read the head for a pop or scan and compact for a full push, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      head         <= '0;
      result_valid <= 1'b0;
      rd_pending   <= 1'b0;
      sh_wr_valid  <= 1'b0;
      found        <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.func)
              perq_pkg::FUNC_PUSH: begin
                if (!full) begin
                  fill         <= fill + CW'(1);
                  result_valid <= 1'b1;
                  result       <= perq_pkg::make_rsp(perq_pkg::ST_ACCEPTED, 1'b0, in_entry,
                                                     7'(fill + CW'(1)), 1'b1);
                end else begin
                  pend       <= in_entry;
                  issue_cnt  <= '0;
                  rd_pending <= 1'b0;
                  lowest     <= cmd.priority_req;
                  found      <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              perq_pkg::FUNC_POP: begin
                if (fill == '0) begin
                  result_valid <= 1'b1;
                  result       <= perq_pkg::make_rsp(perq_pkg::ST_EMPTY, 1'b0, in_entry,
                                                     7'd0, 1'b1);
                end else begin
                  state <= S_POP;
                end
              end
              perq_pkg::FUNC_FLUSH: begin
                fill         <= '0;
                result_valid <= 1'b1;
                result       <= perq_pkg::make_rsp(perq_pkg::ST_FLUSHED, 1'b0, in_entry,
                                                   7'd0, 1'b1);
              end
              default: begin
                // drop the unused code
              end
            endcase
          end
        end

        S_POP: begin
          // Report the head and advance past it
          head         <= phys(head, CW'(1));
          fill         <= fill - CW'(1);
          result_valid <= 1'b1;
          result       <= perq_pkg::make_rsp(perq_pkg::ST_DEQUEUED, 1'b1, rd_data,
                                             7'(fill - CW'(1)), 1'b1);
          state        <= S_IDLE;
        end

        S_SCAN: begin
          // Issue one read per cycle, compare the registered data of the previous read
          if (scan_issue) begin
            issue_cnt <= issue_cnt + CW'(1);
            cmp_idx   <= issue_cnt[AW-1:0];
          end
          rd_pending <= scan_issue;
          if (rd_pending && rd_data.priority_val < lowest) begin
            lowest   <= rd_data.priority_val;
            best_idx <= cmp_idx;
            best     <= rd_data;
            found    <= 1'b1;
          end
          if (!scan_issue && !rd_pending) begin
            result_valid <= 1'b1;
            if (found) begin
              result      <= perq_pkg::make_rsp(perq_pkg::ST_EVICTED, 1'b1, best,
                                                7'(fill), 1'b0);
              sh_rd       <= CW'(best_idx) + CW'(1);
              sh_wr_valid <= 1'b0;
              state       <= S_SHIFT;
            end else begin
              result <= perq_pkg::make_rsp(perq_pkg::ST_REJECTED, 1'b0, best,
                                           7'(fill), 1'b1);
              state  <= S_IDLE;
            end
          end
        end

        S_SHIFT: begin
          // Move each later entry one place toward the head, then append
          if (shift_issue) begin
            sh_rd     <= sh_rd + CW'(1);
            sh_wr_idx <= AW'(sh_rd - CW'(1));
          end
          sh_wr_valid <= shift_issue;
          if (!shift_issue && !sh_wr_valid) begin
            result_valid <= 1'b1;
            result       <= perq_pkg::make_rsp(perq_pkg::ST_ACCEPTED, 1'b0, pend,
                                               7'(fill), 1'b1);
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/perq_store.sv
// Entry memory: one write port, one read port with registered read data.
module perq_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  perq_pkg::entry_t       wr_data,
  input  logic [AW-1:0]          rd_addr,
  output perq_pkg::entry_t       rd_data
);

  perq_pkg::entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
